@@ hdl/gcg_pkg.sv @@
// ----------------------------------------------------------------------------
// Gold code chip generator package
// Shared constants, register indexes, status codes and the built-in
// initial-value and delay tables of the second shift register.
// ----------------------------------------------------------------------------
package gcg_pkg;

    localparam int NUM_PRNS_DEF  = 210;
    localparam int REG_BITS_DEF  = 11;
    localparam int ROM_ENTRIES   = 210;
    localparam int TAP_BITS      = 11;
    localparam int LEN_CFG_BITS  = 4;
    localparam int CODE_BITS     = 12;
    localparam int DELAY_BITS    = 11;
    localparam int PRN_BITS      = 8;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [TAP_BITS-1:0]     FIRST_INIT      = 11'h3FF;
    localparam logic [TAP_BITS-1:0]     G1_TAPS_RST     = '0;
    localparam logic [TAP_BITS-1:0]     G2_TAPS_RST     = '0;
    localparam logic [LEN_CFG_BITS-1:0] REG_LENGTH_RST  = 4'd10;
    localparam logic [CODE_BITS-1:0]    CODE_LENGTH_RST = 12'd2046;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_G1_TAPS     = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_G2_TAPS     = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_REG_LENGTH  = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CODE_LENGTH = 2'd3;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_CHIP = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_PRN = 2'd1;
    localparam logic [1:0] ST_NO_CODE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_STEP2,
        S_DONE
    } t_state;

    localparam logic [TAP_BITS-1:0] INIT_TABLE [0:ROM_ENTRIES-1] = '{
        11'h514, 11'h59E, 11'h49A, 11'h346, 11'h788, 11'h341, 11'h170, 11'h7AB, 11'h301, 11'h32E,
        11'h4DE, 11'h290, 11'h4ED, 11'h506, 11'h30E, 11'h230, 11'h270, 11'h380, 11'h2DC, 11'h5C8,
        11'h61E, 11'h720, 11'h548, 11'h770, 11'h32F, 11'h600, 11'h635, 11'h487, 11'h730, 11'h4BE,
        11'h55F, 11'h775, 11'h424, 11'h603, 11'h450, 11'h0AB, 11'h316, 11'h44F, 11'h477, 11'h76F,
        11'h1F3, 11'h189, 11'h6BE, 11'h6EB, 11'h336, 11'h650, 11'h590, 11'h74F, 11'h294, 11'h03F,
        11'h5AB, 11'h4F2, 11'h647, 11'h494, 11'h521, 11'h53D, 11'h4DF, 11'h4A2, 11'h2C3, 11'h15F,
        11'h3A2, 11'h209, 11'h329, 11'h0A9, 11'h532, 11'h733, 11'h697, 11'h6DD, 11'h2FC, 11'h471,
        11'h428, 11'h706, 11'h52F, 11'h77F, 11'h526, 11'h7FB, 11'h220, 11'h13C, 11'h65F, 11'h7E3,
        11'h254, 11'h444, 11'h041, 11'h542, 11'h6EF, 11'h4F6, 11'h708, 11'h45F, 11'h654, 11'h659,
        11'h486, 11'h72A, 11'h191, 11'h68D, 11'h0CD, 11'h5FE, 11'h604, 11'h282, 11'h36D, 11'h231,
        11'h655, 11'h1FF, 11'h6FB, 11'h41F, 11'h6AC, 11'h026, 11'h298, 11'h612, 11'h100, 11'h2C7,
        11'h534, 11'h7BE, 11'h7DA, 11'h510, 11'h39A, 11'h786, 11'h354, 11'h5A4, 11'h1A4, 11'h529,
        11'h4CE, 11'h5F2, 11'h280, 11'h30D, 11'h621, 11'h572, 11'h455, 11'h4C5, 11'h51E, 11'h676,
        11'h53C, 11'h726, 11'h410, 11'h544, 11'h430, 11'h3AC, 11'h468, 11'h389, 11'h7DE, 11'h3CD,
        11'h7FD, 11'h0BB, 11'h600, 11'h6F9, 11'h61A, 11'h7EA, 11'h798, 11'h75A, 11'h307, 11'h5D1,
        11'h541, 11'h689, 11'h71E, 11'h330, 11'h498, 11'h377, 11'h664, 11'h476, 11'h6BB, 11'h55E,
        11'h340, 11'h440, 11'h1DE, 11'h650, 11'h302, 11'h32C, 11'h2CD, 11'h50A, 11'h31A, 11'h459,
        11'h750, 11'h5D2, 11'h4F3, 11'h779, 11'h538, 11'h719, 11'h146, 11'h1E4, 11'h5E3, 11'h554,
        11'h584, 11'h288, 11'h226, 11'h594, 11'h4D4, 11'h48C, 11'h020, 11'h44E, 11'h43A, 11'h6F0,
        11'h7C5, 11'h331, 11'h7BD, 11'h443, 11'h46A, 11'h758, 11'h357, 11'h22C, 11'h385, 11'h643,
        11'h648, 11'h4D3, 11'h282, 11'h530, 11'h760, 11'h6E4, 11'h485, 11'h679, 11'h112, 11'h2DE
    };

    localparam logic [DELAY_BITS-1:0] DELAY_TABLE [0:ROM_ENTRIES-1] = '{
        11'd1845, 11'd1071, 11'd170,  11'd2035, 11'd1214, 11'd1292, 11'd1284, 11'd1894,
        11'd1537, 11'd735,  11'd561,  11'd1789, 11'd1453, 11'd196,  11'd1040, 11'd326,
        11'd1787, 11'd982,  11'd1030, 11'd1380, 11'd1932, 11'd1188, 11'd390,  11'd714,
        11'd303,  11'd1001, 11'd707,  11'd1984, 11'd139,  11'd182,  11'd1891, 11'd1247,
        11'd1434, 11'd2000, 11'd1843, 11'd865,  11'd616,  11'd514,  11'd449,  11'd1173,
        11'd24,   11'd1383, 11'd1940, 11'd1594, 11'd1765, 11'd752,  11'd145,  11'd1615,
        11'd1666, 11'd1372, 11'd1634, 11'd1068, 11'd1181, 11'd879,  11'd1153, 11'd1621,
        11'd927,  11'd1848, 11'd402,  11'd413,  11'd1090, 11'd657,  11'd609,  11'd1547,
        11'd370,  11'd271,  11'd1353, 11'd635,  11'd299,  11'd697,  11'd152,  11'd678,
        11'd1329, 11'd15,   11'd1974, 11'd1884, 11'd1868, 11'd277,  11'd302,  11'd9,
        11'd603,  11'd1583, 11'd848,  11'd1234, 11'd1568, 11'd510,  11'd1303, 11'd1921,
        11'd823,  11'd1187, 11'd1299, 11'd824,  11'd672,  11'd2034, 11'd1388, 11'd13,
        11'd223,  11'd1840, 11'd1161, 11'd1132, 11'd365,  11'd2,    11'd924,  11'd1373,
        11'd959,  11'd220,  11'd1542, 11'd188,  11'd264,  11'd453,  11'd68,   11'd715,
        11'd75,   11'd1095, 11'd938,  11'd1316, 11'd394,  11'd1156, 11'd166,  11'd969,
        11'd269,  11'd179,  11'd957,  11'd400,  11'd625,  11'd1513, 11'd1796, 11'd100,
        11'd1660, 11'd1454, 11'd1613, 11'd1064, 11'd844,  11'd518,  11'd320,  11'd661,
        11'd2031, 11'd694,  11'd1143, 11'd1167, 11'd1885, 11'd833,  11'd1601, 11'd903,
        11'd399,  11'd1896, 11'd899,  11'd133,  11'd556,  11'd331,  11'd198,  11'd212,
        11'd1024, 11'd1070, 11'd1972, 11'd1573, 11'd884,  11'd1177, 11'd1691, 11'd533,
        11'd480,  11'd751,  11'd447,  11'd734,  11'd973,  11'd857,  11'd1767, 11'd1548,
        11'd1876, 11'd614,  11'd1017, 11'd1978, 11'd275,  11'd1141, 11'd1252, 11'd1952,
        11'd1714, 11'd1067, 11'd557,  11'd522,  11'd1159, 11'd545,  11'd1580, 11'd610,
        11'd935,  11'd1134, 11'd780,  11'd691,  11'd1038, 11'd1418, 11'd295,  11'd916,
        11'd1654, 11'd624,  11'd706,  11'd1033, 11'd1633, 11'd790,  11'd1451, 11'd1300,
        11'd459,  11'd106,  11'd861,  11'd1541, 11'd114,  11'd1381, 11'd1945, 11'd1069,
        11'd242,  11'd356
    };

    // Entries past the defined table read as zero.
    function automatic logic [TAP_BITS-1:0] init_value(input logic [PRN_BITS-1:0] idx);
        logic [TAP_BITS-1:0] val;
        val = '0;
        if (32'(idx) < ROM_ENTRIES) begin
            val = INIT_TABLE[idx];
        end
        return val;
    endfunction

    function automatic logic [DELAY_BITS-1:0] delay_value(input logic [PRN_BITS-1:0] idx);
        logic [DELAY_BITS-1:0] val;
        val = '0;
        if (32'(idx) < ROM_ENTRIES) begin
            val = DELAY_TABLE[idx];
        end
        return val;
    endfunction

endpackage

@@ hdl/gcg_req_if.sv @@
// ----------------------------------------------------------------------------
// Gold code request channel
// Valid/ready channel that carries load and next-chip requests.
// ----------------------------------------------------------------------------
interface gcg_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [gcg_pkg::PRN_BITS-1:0]  prn;

    modport source (output valid, output req_type, output prn, input ready);
    modport sink   (input valid, input req_type, input prn, output ready);
endinterface

@@ hdl/gcg_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Gold code response channel
// Valid/ready channel that carries one result per request.
// ----------------------------------------------------------------------------
interface gcg_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          chip;
    logic [gcg_pkg::CODE_BITS-1:0] chip_index;
    logic                          last_chip;
    logic [1:0]                    status;

    modport source (output valid, output chip, output chip_index, output last_chip,
                    output status, input ready);
    modport sink   (input valid, input chip, input chip_index, input last_chip,
                    input status, output ready);
endinterface

@@ hdl/gold_code_chip_generator.sv @@
// ----------------------------------------------------------------------------
// Gold code chip generator
// Two shift registers with a shared step unit produce Gold code chips.
// ----------------------------------------------------------------------------
// Usage:
// A transaction on i_req with req_type load names a PRN. The first register
// is set to its start value, the second is loaded from the initial-value
// table and stepped as many times as the delay table gives. A transaction
// with req_type chip returns the XOR of the low bits of both registers and
// steps both. Every request yields exactly one transaction on o_rsp.
// Timing: the step unit serves one register per cycle. A chip request goes
// through the pending result register and the second-register step to the
// final state; a valid load first steps the second register once per delay
// count (delay up to 2047); a rejected request goes straight to the final
// state. i_req.ready is high only while the sequencer is idle.
// The result register holds while o_rsp.ready is low; the sequencer waits
// in its final state until the register is free, so nothing is dropped.
// Configuration writes on i_cfg_* are taken at any time but are meant for
// idle periods. Synchronous reset clears the sequencer, the result valid flag,
// the code state and the configuration to its defaults.
// ----------------------------------------------------------------------------
module gold_code_chip_generator #(
    parameter int NUM_PRNS = gcg_pkg::NUM_PRNS_DEF,
    parameter int REG_BITS = gcg_pkg::REG_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wen,
    input  logic [gcg_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [gcg_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    gcg_req_if.sink                            i_req,
    gcg_rsp_if.source                          o_rsp
);

    localparam int LEN_BITS = $clog2(REG_BITS + 1);

    logic [gcg_pkg::TAP_BITS-1:0]     r_g1_taps;
    logic [gcg_pkg::TAP_BITS-1:0]     r_g2_taps;
    logic [gcg_pkg::LEN_CFG_BITS-1:0] r_reg_length;
    logic [gcg_pkg::CODE_BITS-1:0]    r_code_length;

    gcg_pkg::t_state                  r_state, n_state;
    logic [REG_BITS-1:0]              r_g1, n_g1;
    logic [REG_BITS-1:0]              r_g2, n_g2;
    logic [gcg_pkg::CODE_BITS-1:0]    r_counter, n_counter;
    logic                             r_active, n_active;
    logic [gcg_pkg::DELAY_BITS-1:0]   r_count, n_count;

    logic                             r_p_chip, n_p_chip;
    logic [gcg_pkg::CODE_BITS-1:0]    r_p_index, n_p_index;
    logic                             r_p_last, n_p_last;
    logic [1:0]                       r_p_status, n_p_status;

    logic                             r_out_valid, n_out_valid;
    logic                             r_out_chip;
    logic [gcg_pkg::CODE_BITS-1:0]    r_out_index;
    logic                             r_out_last;
    logic [1:0]                       r_out_status;

    logic                             in_accept;
    logic                             out_load;
    logic                             bad_prn;
    logic [gcg_pkg::PRN_BITS-1:0]     rom_idx;
    logic [LEN_BITS-1:0]              eff_len;
    logic [REG_BITS-1:0]              g1_taps;
    logic [REG_BITS-1:0]              g2_taps;
    logic                             use_g2;
    logic [REG_BITS-1:0]              step_in;
    logic [REG_BITS-1:0]              step_taps;
    logic [REG_BITS-1:0]              step_out;
    logic [gcg_pkg::CODE_BITS-1:0]    period;
    logic [gcg_pkg::CODE_BITS:0]      next_count;
    logic                             ends;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_taps     <= gcg_pkg::G1_TAPS_RST;
            r_g2_taps     <= gcg_pkg::G2_TAPS_RST;
            r_reg_length  <= gcg_pkg::REG_LENGTH_RST;
            r_code_length <= gcg_pkg::CODE_LENGTH_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_addr)
                gcg_pkg::CFG_G1_TAPS:     r_g1_taps     <= i_cfg_data[gcg_pkg::TAP_BITS-1:0];
                gcg_pkg::CFG_G2_TAPS:     r_g2_taps     <= i_cfg_data[gcg_pkg::TAP_BITS-1:0];
                gcg_pkg::CFG_REG_LENGTH:  r_reg_length  <= i_cfg_data[gcg_pkg::LEN_CFG_BITS-1:0];
                gcg_pkg::CFG_CODE_LENGTH: r_code_length <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (32'(r_reg_length) < 2) begin
            eff_len = LEN_BITS'(2);
        end else if (32'(r_reg_length) > REG_BITS) begin
            eff_len = LEN_BITS'(REG_BITS);
        end else begin
            eff_len = LEN_BITS'(r_reg_length);
        end
    end

    assign g1_taps    = REG_BITS'(r_g1_taps);
    assign g2_taps    = REG_BITS'(r_g2_taps);
    assign use_g2     = (r_state == gcg_pkg::S_LOAD) || (r_state == gcg_pkg::S_STEP2);
    assign step_in    = use_g2 ? r_g2 : r_g1;
    assign step_taps  = use_g2 ? g2_taps : g1_taps;

    gcg_lfsr_step #(
        .REG_BITS (REG_BITS)
    ) u_step (
        .i_state (step_in),
        .i_taps  (step_taps),
        .i_len   (eff_len),
        .o_next  (step_out)
    );

    assign in_accept  = i_req.valid && i_req.ready;
    assign out_load   = (r_state == gcg_pkg::S_DONE) && (!r_out_valid || o_rsp.ready);
    assign bad_prn    = (i_req.prn == '0) || (32'(i_req.prn) > NUM_PRNS);
    assign rom_idx    = i_req.prn - gcg_pkg::PRN_BITS'(1);
    assign period     = (r_code_length == '0) ? gcg_pkg::CODE_BITS'(1) : r_code_length;
    assign next_count = {1'b0, r_counter} + (gcg_pkg::CODE_BITS + 1)'(1);
    assign ends       = next_count >= {1'b0, period};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gcg_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_req.req_type == gcg_pkg::REQ_LOAD) begin
                        if (!bad_prn && gcg_pkg::delay_value(rom_idx) != '0) begin
                            n_state = gcg_pkg::S_LOAD;
                        end else begin
                            n_state = gcg_pkg::S_DONE;
                        end
                    end else if (r_active) begin
                        n_state = gcg_pkg::S_STEP2;
                    end else begin
                        n_state = gcg_pkg::S_DONE;
                    end
                end
            end
            gcg_pkg::S_LOAD: begin
                if (r_count == gcg_pkg::DELAY_BITS'(1)) begin
                    n_state = gcg_pkg::S_DONE;
                end
            end
            gcg_pkg::S_STEP2: n_state = gcg_pkg::S_DONE;
            gcg_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = gcg_pkg::S_IDLE;
                end
            end
            default: n_state = gcg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_g1       = r_g1;
        n_g2       = r_g2;
        n_counter  = r_counter;
        n_active   = r_active;
        n_count    = r_count;
        n_p_chip   = r_p_chip;
        n_p_index  = r_p_index;
        n_p_last   = r_p_last;
        n_p_status = r_p_status;
        unique case (r_state)
            gcg_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_p_chip   = 1'b0;
                    n_p_index  = '0;
                    n_p_last   = 1'b0;
                    n_p_status = gcg_pkg::ST_OK;
                    if (i_req.req_type == gcg_pkg::REQ_LOAD) begin
                        if (bad_prn) begin
                            n_active   = 1'b0;
                            n_p_status = gcg_pkg::ST_BAD_PRN;
                        end else begin
                            n_g1      = REG_BITS'(gcg_pkg::FIRST_INIT);
                            n_g2      = REG_BITS'(gcg_pkg::init_value(rom_idx));
                            n_count   = gcg_pkg::delay_value(rom_idx);
                            n_counter = '0;
                            n_active  = 1'b1;
                        end
                    end else if (r_active) begin
                        n_p_chip  = r_g1[0] ^ r_g2[0];
                        n_p_index = r_counter;
                        n_p_last  = ends;
                        n_g1      = step_out;
                        n_counter = next_count[gcg_pkg::CODE_BITS-1:0];
                        if (ends) begin
                            n_active = 1'b0;
                        end
                    end else begin
                        n_p_status = gcg_pkg::ST_NO_CODE;
                    end
                end
            end
            gcg_pkg::S_LOAD: begin
                n_g2    = step_out;
                n_count = r_count - gcg_pkg::DELAY_BITS'(1);
            end
            gcg_pkg::S_STEP2: n_g2 = step_out;
            gcg_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gcg_pkg::S_IDLE;
            r_g1        <= REG_BITS'(gcg_pkg::FIRST_INIT);
            r_g2        <= '0;
            r_counter   <= '0;
            r_active    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_g1        <= n_g1;
            r_g2        <= n_g2;
            r_counter   <= n_counter;
            r_active    <= n_active;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_chip   <= n_p_chip;
        r_p_index  <= n_p_index;
        r_p_last   <= n_p_last;
        r_p_status <= n_p_status;
        if (out_load) begin
            r_out_chip   <= r_p_chip;
            r_out_index  <= r_p_index;
            r_out_last   <= r_p_last;
            r_out_status <= r_p_status;
        end
    end

    assign i_req.ready      = (r_state == gcg_pkg::S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.chip       = r_out_chip;
    assign o_rsp.chip_index = r_out_index;
    assign o_rsp.last_chip  = r_out_last;
    assign o_rsp.status     = r_out_status;

`ifndef SYNTHESIS
    a_chip_goes_to_step2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_req.req_type == gcg_pkg::REQ_CHIP && r_active
        |=> r_state == gcg_pkg::S_STEP2)
        else $error("Chip request did not step the second register.");

    a_load_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gcg_pkg::S_LOAD |-> r_count != '0)
        else $error("Pre-shift running with an empty step count.");

    a_active_falls_on_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_active) && $past(i_rst_n) |-> $past(in_accept))
        else $error("Code state cleared without an accepted request.");

    a_error_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && r_p_status != gcg_pkg::ST_OK |-> !r_p_chip && !r_p_last && r_p_index == '0)
        else $error("Rejected request carries chip data.");
`endif

endmodule

@@ hdl/gcg_lfsr_step.sv @@
// ----------------------------------------------------------------------------
// Shift register step unit
// One Fibonacci step: parity of the tapped low stages, shift right and
// insert the parity at the top used stage.
// ----------------------------------------------------------------------------
module gcg_lfsr_step #(
    parameter int  REG_BITS = gcg_pkg::REG_BITS_DEF,
    localparam int LEN_BITS = $clog2(REG_BITS + 1)
) (
    input  logic [REG_BITS-1:0] i_state,
    input  logic [REG_BITS-1:0] i_taps,
    input  logic [LEN_BITS-1:0] i_len,
    output logic [REG_BITS-1:0] o_next
);

    logic                parity;
    logic [LEN_BITS-1:0] top_pos;
    logic [REG_BITS-1:0] shifted;

    always_comb begin
        parity  = 1'b0;
        top_pos = i_len - LEN_BITS'(1);
        shifted = i_state >> 1;
        for (int k = 0; k < REG_BITS; k++) begin
            if (LEN_BITS'(k) < i_len) begin
                parity = parity ^ (i_state[k] & i_taps[k]);
            end
        end
        for (int k = 0; k < REG_BITS; k++) begin
            o_next[k] = shifted[k] | (parity & (LEN_BITS'(k) == top_pos));
        end
    end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Gold code chip generator testbench
// Drives load and next-chip requests through the request channel with random
// gaps, predicts every response from a behavioral copy of the two shift
// registers, and compares each response field by field. The tap masks,
// register length and code length are rewritten between quiet phases.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT    = 31;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic                         req_type;
        logic [gcg_pkg::PRN_BITS-1:0] prn;
    } t_gold_req;

    typedef struct packed {
        logic                          chip;
        logic [gcg_pkg::CODE_BITS-1:0] chip_index;
        logic                          last_chip;
        logic [1:0]                    status;
    } t_chip_rsp;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              cfg_wen;
    logic [gcg_pkg::CFG_ADDR_BITS-1:0] cfg_addr;
    logic [gcg_pkg::CFG_DATA_BITS-1:0] cfg_data;

    gcg_req_if req_ch ();
    gcg_rsp_if rsp_ch ();

    gold_code_chip_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (cfg_wen),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    t_gold_req pending_reqs[$];
    t_chip_rsp expected_chips[$];

    int issued_count = 0;
    int sent_count   = 0;
    int done_count   = 0;
    int mismatches   = 0;
    int stall_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    logic [gcg_pkg::TAP_BITS-1:0]     cfg_g1_taps  = gcg_pkg::G1_TAPS_RST;
    logic [gcg_pkg::TAP_BITS-1:0]     cfg_g2_taps  = gcg_pkg::G2_TAPS_RST;
    logic [gcg_pkg::LEN_CFG_BITS-1:0] cfg_reg_len  = gcg_pkg::REG_LENGTH_RST;
    logic [gcg_pkg::CODE_BITS-1:0]    cfg_code_len = gcg_pkg::CODE_LENGTH_RST;

    logic [gcg_pkg::TAP_BITS-1:0]  g1_state    = gcg_pkg::FIRST_INIT;
    logic [gcg_pkg::TAP_BITS-1:0]  g2_state    = '0;
    logic [gcg_pkg::CODE_BITS-1:0] chip_count  = '0;
    logic                          code_active = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [gcg_pkg::TAP_BITS-1:0] lfsr_shift(
        input logic [gcg_pkg::TAP_BITS-1:0] r,
        input logic [gcg_pkg::TAP_BITS-1:0] taps
    );
        int                           n;
        logic [gcg_pkg::TAP_BITS-1:0] sel;
        logic [gcg_pkg::TAP_BITS-1:0] low_mask;
        n = int'(cfg_reg_len);
        if (n < 2) n = 2;
        if (n > gcg_pkg::REG_BITS_DEF) n = gcg_pkg::REG_BITS_DEF;
        low_mask = (gcg_pkg::TAP_BITS'(1) << n) - gcg_pkg::TAP_BITS'(1);
        sel = r & taps & low_mask;
        return (r >> 1) | (gcg_pkg::TAP_BITS'(^sel) << (n - 1));
    endfunction

    function automatic t_chip_rsp gold_step(input t_gold_req rq);
        t_chip_rsp r;
        int        period;
        int        steps;
        logic      ends;
        r = '0;
        if (rq.req_type == gcg_pkg::REQ_LOAD) begin
            if (rq.prn == '0 || int'(rq.prn) > gcg_pkg::NUM_PRNS_DEF) begin
                code_active = 1'b0;
                r.status = gcg_pkg::ST_BAD_PRN;
            end else begin
                g1_state = gcg_pkg::FIRST_INIT;
                g2_state = gcg_pkg::INIT_TABLE[int'(rq.prn) - 1];
                steps = int'(gcg_pkg::DELAY_TABLE[int'(rq.prn) - 1]);
                for (int k = 0; k < steps; k++) g2_state = lfsr_shift(g2_state, cfg_g2_taps);
                chip_count = '0;
                code_active = 1'b1;
                r.status = gcg_pkg::ST_OK;
            end
        end else if (!code_active) begin
            r.status = gcg_pkg::ST_NO_CODE;
        end else begin
            period = (cfg_code_len == '0) ? 1 : int'(cfg_code_len);
            ends = (int'(chip_count) + 1) >= period;
            r.chip = g1_state[0] ^ g2_state[0];
            r.chip_index = chip_count;
            r.last_chip = ends;
            r.status = gcg_pkg::ST_OK;
            g1_state = lfsr_shift(g1_state, cfg_g1_taps);
            g2_state = lfsr_shift(g2_state, cfg_g2_taps);
            chip_count = chip_count + 1'b1;
            if (ends) code_active = 1'b0;
        end
        return r;
    endfunction

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = gcg_pkg::REQ_LOAD;
        req_ch.prn = '0;
        rsp_ch.ready = 1'b0;
        cfg_wen = 1'b0;
        cfg_addr = gcg_pkg::CFG_G1_TAPS;
        cfg_data = '0;
        i_rst_n = 1'b0;
    end

    // Request driver.
    always @(posedge i_clk) begin
        t_gold_req nxt;
        bit        calm;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_chips.insert(expected_chips.size(),
                                      gold_step(t_gold_req'{req_ch.req_type, req_ch.prn}));
                sent_count++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                calm = (sent_count >= 400 && sent_count < 600);
                if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = pending_reqs.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.req_type <= nxt.req_type;
                    req_ch.prn <= nxt.prn;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off so that the block backs up into the request channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && done_count == 850) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Response monitor.
    always @(posedge i_clk) begin
        t_chip_rsp got;
        t_chip_rsp want;
        bit        calm;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = '{rsp_ch.chip, rsp_ch.chip_index, rsp_ch.last_chip, rsp_ch.status};
                if (expected_chips.size() == 0) begin
                    if (mismatches < 10)
                        $display("ERROR: unexpected response chip=%0d index=%0d last=%0d status=%0d",
                                 got.chip, got.chip_index, got.last_chip, got.status);
                    mismatches++;
                end else begin
                    want = expected_chips.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("ERROR: response %0d expected chip=%0d index=%0d last=%0d status=%0d",
                                     done_count, want.chip, want.chip_index, want.last_chip,
                                     want.status);
                            $display("       got chip=%0d index=%0d last=%0d status=%0d",
                                     got.chip, got.chip_index, got.last_chip, got.status);
                        end
                        mismatches++;
                    end
                end
                done_count++;
            end
            calm = (done_count >= 400 && done_count < 600);
            if (hold_left > 0)
                rsp_ch.ready <= 1'b0;
            else
                rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_req(input t_gold_req rq);
        pending_reqs.insert(pending_reqs.size(), rq);
        issued_count++;
    endtask

    task automatic push_load(input int prn);
        queue_req(t_gold_req'{gcg_pkg::REQ_LOAD, gcg_pkg::PRN_BITS'(prn)});
    endtask

    task automatic push_chips(input int n);
        for (int k = 0; k < n; k++) begin
            queue_req(t_gold_req'{gcg_pkg::REQ_CHIP, gcg_pkg::PRN_BITS'($urandom_range(255))});
        end
    endtask

    task automatic wait_drained();
        while (done_count < issued_count) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [gcg_pkg::CFG_DATA_BITS-1:0] g1,
                                input logic [gcg_pkg::CFG_DATA_BITS-1:0] g2,
                                input logic [gcg_pkg::CFG_DATA_BITS-1:0] len,
                                input logic [gcg_pkg::CFG_DATA_BITS-1:0] code);
        @(posedge i_clk);
        cfg_wen <= 1'b1;
        cfg_addr <= gcg_pkg::CFG_G1_TAPS;
        cfg_data <= g1;
        @(posedge i_clk);
        cfg_addr <= gcg_pkg::CFG_G2_TAPS;
        cfg_data <= g2;
        @(posedge i_clk);
        cfg_addr <= gcg_pkg::CFG_REG_LENGTH;
        cfg_data <= len;
        @(posedge i_clk);
        cfg_addr <= gcg_pkg::CFG_CODE_LENGTH;
        cfg_data <= code;
        @(posedge i_clk);
        cfg_wen <= 1'b0;
        cfg_g1_taps = g1[gcg_pkg::TAP_BITS-1:0];
        cfg_g2_taps = g2[gcg_pkg::TAP_BITS-1:0];
        cfg_reg_len = len[gcg_pkg::LEN_CFG_BITS-1:0];
        cfg_code_len = code;
        @(posedge i_clk);
    endtask

    task automatic random_config();
        logic [gcg_pkg::CFG_DATA_BITS-1:0] g1;
        logic [gcg_pkg::CFG_DATA_BITS-1:0] g2;
        logic [gcg_pkg::CFG_DATA_BITS-1:0] len;
        logic [gcg_pkg::CFG_DATA_BITS-1:0] code;
        int                                pick;
        g1 = gcg_pkg::CFG_DATA_BITS'($urandom_range(4095));
        g2 = gcg_pkg::CFG_DATA_BITS'($urandom_range(4095));
        if ($urandom_range(9) == 0) g1 = '0;
        if ($urandom_range(9) == 0) g2 = 12'hFFF;
        len = gcg_pkg::CFG_DATA_BITS'($urandom_range(9) < 8 ? $urandom_range(2, 11)
                                                             : $urandom_range(15));
        if ($urandom_range(3) == 0)
            len[gcg_pkg::CFG_DATA_BITS-1:gcg_pkg::LEN_CFG_BITS] = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 70) code = gcg_pkg::CFG_DATA_BITS'($urandom_range(1, 40));
        else if (pick < 85) code = gcg_pkg::CFG_DATA_BITS'($urandom_range(41, 300));
        else if (pick < 95) code = '0;
        else code = 12'd4095;
        write_config(g1, g2, len, code);
    endtask

    task automatic random_traffic(input int budget);
        int left;
        int pick;
        int period;
        int n;
        left = budget;
        period = (cfg_code_len == '0) ? 1 : int'(cfg_code_len);
        while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                push_load($urandom_range(1, gcg_pkg::NUM_PRNS_DEF));
                left--;
                n = period;
                if ($urandom_range(4) == 0) n = $urandom_range(0, period);
                else if ($urandom_range(4) == 0) n = period + $urandom_range(1, 3);
                if (n > left) n = left;
                push_chips(n);
                left -= n;
            end else if (pick < 85) begin
                push_load($urandom_range(3) == 0 ? 0
                                                 : $urandom_range(gcg_pkg::NUM_PRNS_DEF + 1, 255));
                left--;
            end else if (pick < 95) begin
                push_chips(1);
                left--;
            end else begin
                push_load($urandom_range(255));
                left--;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_chips(1);
        push_load(0);
        push_load(gcg_pkg::NUM_PRNS_DEF + 1);
        push_load(255);
        push_load(1);
        push_chips(2);
        push_load(gcg_pkg::NUM_PRNS_DEF);
        push_chips(2);
        wait_drained();

        write_config(12'hFFF, 12'h7FF, 12'd11, 12'd1);
        push_load(102);
        push_chips(2);
        wait_drained();

        write_config(12'h204, 12'h3A6, 12'd2, 12'd4095);
        push_load(41);
        push_chips(3);
        wait_drained();

        write_config(12'h204, 12'h3A6, 12'd0, 12'd0);
        push_load(74);
        push_chips(2);
        wait_drained();

        write_config(12'h000, 12'h7FF, 12'd15, 12'd3);
        push_load(80);
        push_chips(4);
        wait_drained();

        for (int p = 0; p < 13; p++) begin
            random_config();
            random_traffic(110);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (expected_chips.size() != 0) mismatches++;
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
